FILE: sv/anfp_pkg.sv
// Package: shared types, constants and digit decoding for the number field parser.
`default_nettype none
package anfp_pkg;

   localparam logic [7:0]  CH_NUL   = 8'h00;
   localparam logic [7:0]  CH_PLUS  = 8'h2B;
   localparam logic [7:0]  CH_MINUS = 8'h2D;

   localparam logic [31:0] LIM_HEX     = 32'h0FFF_FFFF;
   localparam logic [31:0] LIM_DEC     = 32'h1999_9999;
   localparam logic [3:0]  LIM_DEC_DIG = 4'd5;
   localparam logic [31:0] INT_MAG_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] INT_MAG_NEG = 32'h8000_0000;

   localparam logic [7:0]  MAX_CHARS_RESET = 8'd255;

   typedef enum logic [1:0] {
      CFG_HEX_MODE    = 2'd0,
      CFG_SIGNED_MODE = 2'd1,
      CFG_MAX_CHARS   = 2'd2
   } cfg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_DIGITS    = 2'd1,
      STATUS_OUT_OF_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic       hex_mode;
      logic       signed_mode;
      logic [7:0] max_chars;
   } cfg_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  consumed;
      status_type  status;
      logic        stopped_on_overflow;
   } rsp_item_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c, input logic hex);
      digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         d.valid = 1'b1;
         d.value = c[3:0];
      end else if (hex && (c inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
         d.valid = 1'b1;
         d.value = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: sv/anfp_if.sv
// Interfaces: character input channel and result channel.
`default_nettype none
interface anfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       first;
   logic       last;

   modport source (output valid, output ch, output first, output last, input ready);
   modport sink   (input valid, input ch, input first, input last, output ready);
endinterface

interface anfp_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [31:0]          value;
   logic [7:0]           consumed;
   anfp_pkg::status_type status;
   logic                 stopped_on_overflow;

   modport source (output valid, output value, output consumed, output status,
                   output stopped_on_overflow, input ready);
   modport sink   (input valid, input value, input consumed, input status,
                   input stopped_on_overflow, output ready);
endinterface
`default_nettype wire

FILE: sv/anfp_parse.sv
// Field state registers and the per-character parse step.
`default_nettype none
module anfp_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire anfp_pkg::cfg_type      cfg,
   input  wire anfp_pkg::req_item_type item,
   output logic                        res_valid,
   output anfp_pkg::rsp_item_type      res
);

   typedef struct packed {
      logic [31:0] acc;
      logic [7:0]  cnt;
      logic        neg;
      logic        seen;
      logic        done;
   } field_type;

   field_type           state_ff;
   field_type           state_in;
   field_type           base;
   field_type           mid;
   anfp_pkg::digit_type dig;
   logic                fin;
   logic                ovf;
   logic [31:0]         bound;
   logic [31:0]         times_ten;

   always_comb begin
      base = state_ff;
      if (item.first) begin
         base.acc  = 32'd0;
         base.cnt  = 8'd0;
         base.neg  = 1'b0;
         base.seen = 1'b0;
         base.done = 1'b0;
      end
      mid       = base;
      fin       = 1'b0;
      ovf       = 1'b0;
      dig       = anfp_pkg::digit_of(item.ch, cfg.hex_mode);
      times_ten = {base.acc[28:0], 3'b000} + {base.acc[30:0], 1'b0} + {28'd0, dig.value};
      if (!base.done) begin
         if (item.ch == anfp_pkg::CH_NUL || base.cnt >= cfg.max_chars) begin
            fin = 1'b1;
         end else if (cfg.signed_mode && base.cnt == 8'd0 &&
                      (item.ch == anfp_pkg::CH_MINUS || item.ch == anfp_pkg::CH_PLUS)) begin
            mid.neg = (item.ch == anfp_pkg::CH_MINUS);
            mid.cnt = 8'd1;
            fin     = item.last || (mid.cnt >= cfg.max_chars);
         end else if (!dig.valid) begin
            fin = 1'b1;
         end else if (cfg.hex_mode && base.acc > anfp_pkg::LIM_HEX) begin
            fin = 1'b1;
            ovf = 1'b1;
         end else if (!cfg.hex_mode && (base.acc > anfp_pkg::LIM_DEC ||
                      (base.acc == anfp_pkg::LIM_DEC && dig.value > anfp_pkg::LIM_DEC_DIG))) begin
            fin = 1'b1;
            ovf = 1'b1;
         end else begin
            mid.acc  = cfg.hex_mode ? {base.acc[27:0], dig.value} : times_ten;
            mid.seen = 1'b1;
            mid.cnt  = base.cnt + 8'd1;
            fin      = item.last || (mid.cnt >= cfg.max_chars);
         end
      end
      state_in = mid;
      if (fin) begin
         state_in.done = 1'b1;
      end
   end

   always_comb begin
      bound                   = mid.neg ? anfp_pkg::INT_MAG_NEG : anfp_pkg::INT_MAG_POS;
      res_valid               = fin;
      res.value               = 32'd0;
      res.consumed            = mid.cnt;
      res.status              = anfp_pkg::STATUS_OK;
      res.stopped_on_overflow = ovf;
      if (!mid.seen) begin
         res.status = anfp_pkg::STATUS_NO_DIGITS;
      end else if (cfg.signed_mode) begin
         if (mid.acc > bound) begin
            res.status   = anfp_pkg::STATUS_OUT_OF_RANGE;
            res.consumed = mid.cnt - 8'd1;
         end else begin
            res.value = mid.neg ? (32'd0 - mid.acc) : mid.acc;
         end
      end else begin
         res.value = mid.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.acc  <= 32'd0;
         state_ff.cnt  <= 8'd0;
         state_ff.neg  <= 1'b0;
         state_ff.seen <= 1'b0;
         state_ff.done <= 1'b1;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ascii_number_field_parser.sv
// Top level: ASCII hex/decimal number field parser with registered input and result.
//
// Characters arrive one per item on req_chan (ch, first, last). An item with
// first set opens a new field; items with first clear while no field is open
// are dropped. When a field ends, one item leaves on rsp_chan with the value,
// the count of consumed characters, the status and the overflow stop flag.
// An ending character that is not a digit is not consumed and produces the
// result in the same step; characters that produce no result leave nothing.
// A result is registered: its ending character, once accepted, is parsed out
// of the input register into the result register, which drives rsp_chan.
// Throughput: one character per cycle while rsp_chan does not stall, set by
// the single accumulate step (shift by four or multiply by ten) between the input and result registers.
// When rsp_chan stalls, the result register holds; the input register still
// takes one more item, then req_chan.ready drops until the result is taken.
// Reset clears the valid flags of both registers, closes any open field and restores
// hex_mode 0, signed_mode 0, max_chars 255. Write csr_* only while idle.
`default_nettype none
module ascii_number_field_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   anfp_req_if.sink        req_chan,
   anfp_rsp_if.source      rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wr_data
);

   anfp_pkg::cfg_type      cfg_ff;
   anfp_pkg::req_item_type in_item_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   anfp_pkg::rsp_item_type out_item_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   anfp_pkg::rsp_item_type res;
   logic                   res_valid;
   logic                   advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_chan.valid || (in_valid_ff && !advance);
   assign out_valid_in   = (advance && res_valid) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hex_mode    <= 1'b0;
         cfg_ff.signed_mode <= 1'b0;
         cfg_ff.max_chars   <= anfp_pkg::MAX_CHARS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            anfp_pkg::CFG_HEX_MODE:    cfg_ff.hex_mode    <= csr_wr_data[0];
            anfp_pkg::CFG_SIGNED_MODE: cfg_ff.signed_mode <= csr_wr_data[0];
            anfp_pkg::CFG_MAX_CHARS:   cfg_ff.max_chars   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_item_ff.ch    <= req_chan.ch;
         in_item_ff.first <= req_chan.first;
         in_item_ff.last  <= req_chan.last;
      end
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   anfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cfg       (cfg_ff),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.value               = out_item_ff.value;
   assign rsp_chan.consumed            = out_item_ff.consumed;
   assign rsp_chan.status              = out_item_ff.status;
   assign rsp_chan.stopped_on_overflow = out_item_ff.stopped_on_overflow;

   a_fail_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != anfp_pkg::STATUS_OK |-> rsp_chan.value == 32'd0)
      else $error("failed field result carries a nonzero value");

   a_overflow_has_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.stopped_on_overflow
         |-> rsp_chan.status != anfp_pkg::STATUS_NO_DIGITS)
      else $error("overflow stop reported on a field without digits");

   a_consumed_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.consumed <= cfg_ff.max_chars)
      else $error("consumed count exceeds character limit");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_chan.ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("buffered item lost while result stalled");

endmodule
`default_nettype wire

FILE: tb/sv/ascii_number_field_parser_tb.sv
// Testbench: random and directed character streams against a field-level parse predictor.
`default_nettype none
module ascii_number_field_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wr_data = 8'd0;

   anfp_req_if req_chan ();
   anfp_rsp_if rsp_chan ();

   ascii_number_field_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   anfp_pkg::req_item_type char_queue[$];
   anfp_pkg::rsp_item_type field_results[$];

   anfp_pkg::cfg_type live_cfg = '{hex_mode: 1'b0, signed_mode: 1'b0,
                                   max_chars: anfp_pkg::MAX_CHARS_RESET};
   logic [31:0] acc = 32'd0;
   logic [7:0]  char_cnt = 8'd0;
   logic        neg = 1'b0;
   logic        seen = 1'b0;
   logic        closed = 1'b1;

   int tx_idle_pct = 22;
   int rx_idle_pct = 50;
   int stall_req = 0;
   int stall_taken = 0;
   int stall_left = 0;
   int field_items = 0;
   int mismatches = 0;

   string digit_chars = "0123456789abcdefABCDEF";
   string stop_chars = " ,\n+-gxG:/@`aF";
   string dec_edges [7] = '{"4294967295", "4294967296", "2147483647", "2147483648",
                             "2147483649", "0000000000042", "99999999999"};
   string hex_edges [7] = '{"FFFFFFFF", "ffffffff0", "7FFFFFFF", "80000000",
                             "80000001", "100000000", "0000000000001"};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [4:0] char_digit(input logic [7:0] c, input logic hex);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (hex && c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (hex && c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return 5'h10;
   endfunction

   task automatic close_field(input logic ovf);
      anfp_pkg::rsp_item_type r;
      r.value = 32'd0;
      r.consumed = char_cnt;
      r.status = anfp_pkg::STATUS_OK;
      r.stopped_on_overflow = ovf;
      if (!seen) begin
         r.status = anfp_pkg::STATUS_NO_DIGITS;
      end else if (live_cfg.signed_mode) begin
         if (acc > (neg ? anfp_pkg::INT_MAG_NEG : anfp_pkg::INT_MAG_POS)) begin
            r.status = anfp_pkg::STATUS_OUT_OF_RANGE;
            r.consumed = char_cnt - 8'd1;
         end else begin
            r.value = neg ? 32'd0 - acc : acc;
         end
      end else begin
         r.value = acc;
      end
      field_results.push_back(r);
      closed = 1'b1;
   endtask

   task automatic parse_char(input anfp_pkg::req_item_type it);
      logic [4:0] d;
      if (it.first) begin
         acc = 32'd0;
         char_cnt = 8'd0;
         neg = 1'b0;
         seen = 1'b0;
         closed = 1'b0;
      end
      if (closed) return;
      if (it.ch == anfp_pkg::CH_NUL || char_cnt >= live_cfg.max_chars) begin
         close_field(1'b0);
         return;
      end
      if (live_cfg.signed_mode && char_cnt == 8'd0 &&
          (it.ch == anfp_pkg::CH_MINUS || it.ch == anfp_pkg::CH_PLUS)) begin
         neg = (it.ch == anfp_pkg::CH_MINUS);
         char_cnt = 8'd1;
      end else begin
         d = char_digit(it.ch, live_cfg.hex_mode);
         if (d[4]) begin
            close_field(1'b0);
            return;
         end
         if (live_cfg.hex_mode) begin
            if (acc > anfp_pkg::LIM_HEX) begin
               close_field(1'b1);
               return;
            end
            acc = {acc[27:0], d[3:0]};
         end else begin
            if (acc > anfp_pkg::LIM_DEC ||
                (acc == anfp_pkg::LIM_DEC && d[3:0] > anfp_pkg::LIM_DEC_DIG)) begin
               close_field(1'b1);
               return;
            end
            acc = acc * 32'd10 + {28'd0, d[3:0]};
         end
         seen = 1'b1;
         char_cnt = char_cnt + 8'd1;
      end
      if (it.last || char_cnt >= live_cfg.max_chars) close_field(1'b0);
   endtask

   always @(posedge clock) begin
      anfp_pkg::req_item_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.ch    <= 8'd0;
         req_chan.first <= 1'b0;
         req_chan.last  <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (char_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            it = char_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.ch    <= it.ch;
            req_chan.first <= it.first;
            req_chan.last  <= it.last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         parse_char(anfp_pkg::req_item_type'{req_chan.ch, req_chan.first, req_chan.last});
   end

   always @(posedge clock) begin
      if (stall_req != 0 && stall_taken == 0) begin
         stall_left = stall_req;
         stall_taken = 1;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      anfp_pkg::rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (field_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, actual value %h consumed %0d status %0d",
                     $time, rsp_chan.value, rsp_chan.consumed, rsp_chan.status);
         end else begin
            want = field_results.pop_front();
            if (rsp_chan.value !== want.value) begin
               mismatches++;
               $display("%0t: value expected %h actual %h", $time, want.value, rsp_chan.value);
            end
            if (rsp_chan.consumed !== want.consumed) begin
               mismatches++;
               $display("%0t: consumed expected %0d actual %0d",
                        $time, want.consumed, rsp_chan.consumed);
            end
            if (rsp_chan.status !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_chan.status);
            end
            if (rsp_chan.stopped_on_overflow !== want.stopped_on_overflow) begin
               mismatches++;
               $display("%0t: stopped_on_overflow expected %0b actual %0b",
                        $time, want.stopped_on_overflow, rsp_chan.stopped_on_overflow);
            end
         end
      end
   end

   task automatic push_item(input logic [7:0] c, input logic f, input logic l);
      char_queue.push_back(anfp_pkg::req_item_type'{c, f, l});
   endtask

   function automatic logic [7:0] stop_char();
      if ($urandom_range(14) == 0) return anfp_pkg::CH_NUL;
      return stop_chars[$urandom_range(stop_chars.len() - 1)];
   endfunction

   task automatic write_reg(input anfp_pkg::cfg_index_type idx, input logic [7:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         anfp_pkg::CFG_HEX_MODE:    live_cfg.hex_mode = data[0];
         anfp_pkg::CFG_SIGNED_MODE: live_cfg.signed_mode = data[0];
         anfp_pkg::CFG_MAX_CHARS:   live_cfg.max_chars = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic hex, input logic sgn, input logic [7:0] maxc);
      write_reg(anfp_pkg::CFG_HEX_MODE, {7'd0, hex});
      write_reg(anfp_pkg::CFG_SIGNED_MODE, {7'd0, sgn});
      write_reg(anfp_pkg::CFG_MAX_CHARS, maxc);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (char_queue.size() != 0 || req_chan.valid || field_results.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic gen_field();
      logic [7:0] body[$];
      string      pat;
      int         kind;
      int         term;
      int         n;
      kind = $urandom_range(9);
      if ((live_cfg.signed_mode && $urandom_range(2) == 0) || $urandom_range(11) == 0)
         body.push_back($urandom_range(1) ? anfp_pkg::CH_MINUS : anfp_pkg::CH_PLUS);
      if (kind < 2) begin
         pat = live_cfg.hex_mode ? hex_edges[$urandom_range(6)] : dec_edges[$urandom_range(6)];
         for (int i = 0; i < pat.len(); i++) body.push_back(pat[i]);
      end else if (kind > 2) begin
         n = ($urandom_range(4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         repeat (n)
            body.push_back(digit_chars[live_cfg.hex_mode ? $urandom_range(21) : $urandom_range(9)]);
      end
      term = $urandom_range(9);
      if (body.size() == 0 && (term < 4 || term == 8)) term = 4;
      foreach (body[i])
         push_item(body[i], i == 0, term < 4 && i == body.size() - 1);
      field_items += body.size();
      case (term)
         4, 5, 6: begin
            push_item(stop_char(), body.size() == 0, 1'($urandom_range(1)));
            field_items++;
         end
         7: begin
            push_item(8'($urandom_range(255)), body.size() == 0, 1'($urandom_range(1)));
            field_items++;
         end
         9: begin
            push_item(stop_char(), body.size() == 0, 1'($urandom_range(1)));
            field_items++;
            repeat ($urandom_range(1, 3)) begin
               push_item(8'($urandom_range(255)), $urandom_range(7) == 0,
                         1'($urandom_range(1)));
               field_items++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic hex, input logic sgn, input logic [7:0] maxc,
                            input int count);
      set_config(hex, sgn, maxc);
      field_items = 0;
      while (field_items < count) gen_field();
      wait_idle();
   endtask

   initial begin
      string big;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_config(1'b0, 1'b0, 8'd255);
      push_item("x", 1'b0, 1'b0);
      push_item("7", 1'b1, 1'b1);
      push_item(anfp_pkg::CH_NUL, 1'b1, 1'b0);
      push_item("1", 1'b1, 1'b0);
      push_item("2", 1'b0, 1'b0);
      push_item("9", 1'b1, 1'b1);
      big = "4294967295";
      for (int i = 0; i < big.len(); i++)
         push_item(big[i], i == 0, i == big.len() - 1);
      wait_idle();

      set_config(1'b1, 1'b1, 8'd255);
      push_item(anfp_pkg::CH_MINUS, 1'b1, 1'b0);
      push_item("g", 1'b0, 1'b0);
      push_item("a", 1'b1, 1'b0);
      push_item("F", 1'b0, 1'b0);
      push_item(anfp_pkg::CH_PLUS, 1'b0, 1'b1);
      wait_idle();

      set_config(1'b1, 1'b0, 8'd1);
      push_item("f", 1'b1, 1'b0);
      push_item("f", 1'b0, 1'b0);
      wait_idle();

      set_config(1'b0, 1'b0, 8'd0);
      push_item("5", 1'b1, 1'b0);
      wait_idle();

      run_phase(1'b0, 1'b0, 8'd255, 240);
      stall_req = 300;
      run_phase(1'b1, 1'b1, 8'd255, 240);

      tx_idle_pct = 50;
      rx_idle_pct = 22;
      run_phase(1'b1, 1'b0, 8'd8, 240);
      run_phase(1'b0, 1'b1, 8'd1, 240);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(1'b0, 1'b1, 8'd12, 240);
      run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(2, 255)), 240);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
